// File: hdl/touch_frame_decode_scale_unit_macros.svh
// Assertion macros for the touch report decode and scale unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TOUCH_FRAME_DECODE_SCALE_UNIT_MACROS_SVH
`define TOUCH_FRAME_DECODE_SCALE_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define TFDS_ASSERT_IMPL(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define TFDS_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`endif

// File: hdl/tfds_pkg.sv
// Shared types and constants for the touch report decode and scale unit.
// No dependencies.
package tfds_pkg;

	localparam int RAW_W       = 12;
	localparam int MAX_W       = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_X_MAX  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_Y_MAX  = 2'd2;

	// Protocol modes
	localparam logic MODE_FRAME    = 1'b0;
	localparam logic MODE_REGISTER = 1'b1;

	// Register reset values
	localparam logic [MAX_W-1:0] SCREEN_X_MAX_RESET = 16'd239;
	localparam logic [MAX_W-1:0] SCREEN_Y_MAX_RESET = 16'd319;

	// Result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_CHECKSUM  = 2'd1;
	localparam logic [1:0] STATUS_BAD_EVENT = 2'd2;

	// Register-mode event codes
	localparam logic [1:0] EV_DOWN    = 2'd0;
	localparam logic [1:0] EV_UP      = 2'd1;
	localparam logic [1:0] EV_CONTACT = 2'd2;
	localparam logic [1:0] EV_ERROR   = 2'd3;

	localparam logic [7:0] CHECKSUM_SEED = 8'h55;

	typedef struct packed {
		logic [7:0] report_byte_0;
		logic [7:0] report_byte_1;
		logic [7:0] report_byte_3;
		logic [7:0] report_byte_4;
		logic [7:0] report_byte_5;
		logic [7:0] report_byte_6;
		logic [7:0] report_byte_7;
		logic [7:0] report_byte_8;
	} report_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             touching;
		logic [MAX_W-1:0] screen_x;
		logic [MAX_W-1:0] screen_y;
	} result_t;

	typedef struct packed {
		logic             protocol_mode;
		logic [MAX_W-1:0] screen_x_max;
		logic [MAX_W-1:0] screen_y_max;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             touching;
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
	} decode_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// File: hdl/touch_frame_decode_scale_unit.sv
// Top level of the touch report decode and scale unit.
// Depends on tfds_pkg, tfds_cfg, tfds_decode, tfds_scale and the macro header.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------
//   report   | report_valid / report_stall | report   (report_t)
//   result   | result_valid / result_stall | result   (result_t)
//   config   | cfg_write_en                | cfg_index, cfg_data
//
// One report per cycle sustained while the result is not held; each result is
// offered once its report has passed four registers (input register, decode
// and premultiply, reciprocal multiply, correction into the result register).
// Reset clears all stage valid bits and loads the register reset values.
// Each stage moves whenever the stage after it is empty or moving, so a held
// result stalls the input only once every stage is full.
module touch_frame_decode_scale_unit import tfds_pkg::*; #(
	parameter int RAW_X_LIMIT = 239,
	parameter int RAW_Y_LIMIT = 319
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   report_valid,
	output logic                   report_stall,
	input  report_t                report,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	`include "touch_frame_decode_scale_unit_macros.svh"

	cfg_t      cfg;
	stage_en_t en;
	logic      en_s1;
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      valid_s4;
	report_t   report_s1;
	decode_t   dec;
	logic [1:0] status_s2;
	logic [1:0] status_s3;
	logic [1:0] status_s4;
	logic       touch_s2;
	logic       touch_s3;
	logic       touch_s4;
	logic [MAX_W-1:0] scaled_x;
	logic [MAX_W-1:0] scaled_y;

	tfds_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	// Stage enables: advance when the next stage is empty or advancing
	assign en.s4        = !valid_s4 || !result_stall;
	assign en.s3        = !valid_s3 || en.s4;
	assign en.s2        = !valid_s2 || en.s3;
	assign en_s1        = !valid_s1 || en.s2;
	assign report_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= report_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	// Capture the incoming item
	always_ff @(posedge clk) begin
		if (en_s1) begin
			report_s1 <= report;
		end
	end

	tfds_decode #(
		.RAW_X_LIMIT (RAW_X_LIMIT),
		.RAW_Y_LIMIT (RAW_Y_LIMIT)
	) u_decode (
		.report        (report_s1),
		.protocol_mode (cfg.protocol_mode),
		.dec           (dec)
	);

	// Carry status and touch alongside the scalers
	always_ff @(posedge clk) begin
		if (en.s2) begin
			status_s2 <= dec.status;
			touch_s2  <= dec.touching;
		end
		if (en.s3) begin
			status_s3 <= status_s2;
			touch_s3  <= touch_s2;
		end
		if (en.s4) begin
			status_s4 <= status_s3;
			touch_s4  <= touch_s3;
		end
	end

	tfds_scale #(.LIMIT (RAW_X_LIMIT)) u_scale_x (
		.clk     (clk),
		.en      (en),
		.raw     (dec.raw_x),
		.out_max (cfg.screen_x_max),
		.scaled  (scaled_x)
	);

	tfds_scale #(.LIMIT (RAW_Y_LIMIT)) u_scale_y (
		.clk     (clk),
		.en      (en),
		.raw     (dec.raw_y),
		.out_max (cfg.screen_y_max),
		.scaled  (scaled_y)
	);

	assign result_valid    = valid_s4;
	assign result.status   = status_s4;
	assign result.touching = touch_s4;
	assign result.screen_x = scaled_x;
	assign result.screen_y = scaled_y;

	// Input stalls only with every stage full and the result held
	`TFDS_ASSERT_IMPL(a_stall_full, report_stall, valid_s1 && valid_s2 && valid_s3 && valid_s4 && result_stall)
	// Error results carry no touch and no coordinates
	`TFDS_ASSERT_IMPL(a_err_zero, result_valid && (result.status != STATUS_OK), !result.touching && (result.screen_x == '0) && (result.screen_y == '0))
	// Mode write lands in the register
	`TFDS_ASSERT_NEXT(a_mode_write, cfg_write_en && (cfg_index == REG_PROTOCOL_MODE), cfg.protocol_mode == $past(cfg_data[0]))

endmodule

// File: hdl/tfds_cfg.sv
// Configuration registers of the touch report decode and scale unit.
// Depends on tfds_pkg.
module tfds_cfg import tfds_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protocol_mode <= MODE_FRAME;
			cfg_q.screen_x_max  <= SCREEN_X_MAX_RESET;
			cfg_q.screen_y_max  <= SCREEN_Y_MAX_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_PROTOCOL_MODE: cfg_q.protocol_mode <= cfg_data[0];
				REG_SCREEN_X_MAX:  cfg_q.screen_x_max  <= cfg_data[MAX_W-1:0];
				REG_SCREEN_Y_MAX:  cfg_q.screen_y_max  <= cfg_data[MAX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/tfds_decode.sv
// Report decoder: checksum or event check, raw X/Y unpack, clamp, X inversion.
// Depends on tfds_pkg; purely combinational.
module tfds_decode import tfds_pkg::*; #(
	parameter int RAW_X_LIMIT = 239,
	parameter int RAW_Y_LIMIT = 319
) (
	input  report_t report,
	input  logic    protocol_mode,
	output decode_t dec
);

	localparam logic [RAW_W-1:0] X_LIM = RAW_W'(RAW_X_LIMIT);
	localparam logic [RAW_W-1:0] Y_LIM = RAW_W'(RAW_Y_LIMIT);

	logic [15:0]      sum_got;
	logic [15:0]      sum_want;
	logic [1:0]       ev;
	logic [RAW_W-1:0] rx;
	logic [RAW_W-1:0] ry;
	logic [RAW_W-1:0] rx_clamp;
	logic [RAW_W-1:0] ry_clamp;

	assign sum_got  = {report.report_byte_1, report.report_byte_0};
	assign sum_want = 16'(16'(CHECKSUM_SEED) + 16'(report.report_byte_4)
		+ 16'(report.report_byte_5) + 16'(report.report_byte_6)
		+ 16'(report.report_byte_7) + 16'(report.report_byte_8));
	assign ev = report.report_byte_3[7:6];

	// Unpack raw coordinates per protocol; frame X is one-based
	always_comb begin
		if (protocol_mode == MODE_FRAME) begin
			rx = {report.report_byte_7[3:0], report.report_byte_4};
			ry = {report.report_byte_7[7:4], report.report_byte_5};
			if (rx != '0) begin
				rx = rx - RAW_W'(1);
			end
		end else begin
			rx = {report.report_byte_3[3:0], report.report_byte_4};
			ry = {report.report_byte_5[3:0], report.report_byte_6};
		end
	end

	// Saturate to the raw limits
	assign rx_clamp = (rx > X_LIM) ? X_LIM : rx;
	assign ry_clamp = (ry > Y_LIM) ? Y_LIM : ry;

	// Pick status; zero raw values on error so the scaled axes come out zero
	always_comb begin
		dec = '0;
		if (protocol_mode == MODE_FRAME) begin
			if (sum_got != sum_want) begin
				dec.status = STATUS_CHECKSUM;
			end else begin
				dec.status   = STATUS_OK;
				dec.touching = (report.report_byte_8[7:4] != 4'd0);
				dec.raw_x    = X_LIM - rx_clamp;
				dec.raw_y    = ry_clamp;
			end
		end else begin
			if (ev == EV_ERROR) begin
				dec.status = STATUS_BAD_EVENT;
			end else begin
				dec.status   = STATUS_OK;
				dec.touching = (ev == EV_DOWN) || (ev == EV_CONTACT);
				dec.raw_x    = rx_clamp;
				dec.raw_y    = ry_clamp;
			end
		end
	end

endmodule

// File: hdl/tfds_scale.sv
// One-axis scaler: (raw * max + LIMIT/2) / LIMIT over three pipeline stages,
// divide done as reciprocal multiply plus one correction. Depends on tfds_pkg.
module tfds_scale import tfds_pkg::*; #(
	parameter int LIMIT = 239
) (
	input  logic             clk,
	input  stage_en_t        en,
	input  logic [RAW_W-1:0] raw,
	input  logic [MAX_W-1:0] out_max,
	output logic [MAX_W-1:0] scaled
);

	localparam int N_W = RAW_W + MAX_W;
	localparam int Q_W = MAX_W + 1;
	localparam int R_W = Q_W + RAW_W;
	localparam logic [N_W-1:0] HALF  = N_W'(LIMIT / 2);
	localparam logic [N_W:0]   RECIP = (N_W + 1)'((64'd1 << N_W) / LIMIT);
	localparam logic [RAW_W-1:0] DIV = RAW_W'(LIMIT);

	logic [N_W-1:0]     num_s2;
	logic [N_W-1:0]     num_s3;
	logic [Q_W-1:0]     qest_s3;
	logic [2*N_W:0]     prod;
	logic [R_W-1:0]     rem;
	logic [Q_W-1:0]     q_fix;
	logic [MAX_W-1:0]   scaled_s4;

	// Stage 2: numerator with rounding offset
	always_ff @(posedge clk) begin
		if (en.s2) begin
			num_s2 <= N_W'(raw) * N_W'(out_max) + HALF;
		end
	end

	// Stage 3: quotient estimate, low by at most one
	assign prod = (2*N_W + 1)'(num_s2) * (2*N_W + 1)'(RECIP);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			num_s3  <= num_s2;
			qest_s3 <= prod[N_W +: Q_W];
		end
	end

	// Stage 4: bump the estimate when the remainder reaches the divisor
	assign rem   = R_W'(num_s3) - R_W'(qest_s3) * R_W'(DIV);
	assign q_fix = qest_s3 + Q_W'(rem >= R_W'(DIV));

	always_ff @(posedge clk) begin
		if (en.s4) begin
			scaled_s4 <= q_fix[MAX_W-1:0];
		end
	end

	assign scaled = scaled_s4;

endmodule

// File: dv/tb_touch_frame_decode_scale_unit.sv
// Testbench for touch_frame_decode_scale_unit: directed reports, then random phases.
// Each result is checked against a local decode and scale model.
// Depends on tfds_pkg and the unit's RTL.
module tb_touch_frame_decode_scale_unit;
	import tfds_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int X_LIMIT     = 239;
	localparam int Y_LIMIT     = 319;
	localparam int LATENCY     = 4;
	localparam int HOLD_CYCLES = 40;
	localparam int PHASE_ITEMS = 60;
	localparam int NUM_PHASES  = 8;
	localparam int CYCLE_LIMIT = 200000;

	// Index with no register behind it; writes to it must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct {
		logic    mode;
		report_t rpt;
		bit      fixed;
		result_t want;
	} directed_row_t;

	typedef struct {
		logic            mode;
		logic [MAX_W-1:0] x_max;
		logic [MAX_W-1:0] y_max;
		bit              gaps;
	} phase_t;

	logic                   clk;
	logic                   arst_n;
	logic                   report_valid;
	logic                   report_stall;
	report_t                report;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Local copy of the unit's registers
	logic             mode_q;
	logic [MAX_W-1:0] x_max_q;
	logic [MAX_W-1:0] y_max_q;

	result_t       pending_results[$];
	directed_row_t directed_rows[$];
	int            error_count;
	int            checked_count;
	int            cycle_count;
	bit            hold_req;
	bit            quiet;

	touch_frame_decode_scale_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Round-to-nearest scaling of one clamped axis
	function automatic logic [MAX_W-1:0] scale_axis(int unsigned raw, int unsigned out_max,
			int unsigned limit);
		return MAX_W'((raw * out_max + limit / 2) / limit);
	endfunction

	// Expected result of one report under the current register settings
	function automatic result_t decode_and_scale(report_t r);
		result_t          res;
		logic [15:0]      got;
		logic [15:0]      want;
		logic [RAW_W-1:0] rx;
		logic [RAW_W-1:0] ry;
		logic [1:0]       ev;
		res = '0;
		if (mode_q == MODE_FRAME) begin
			got  = {r.report_byte_1, r.report_byte_0};
			want = 16'(CHECKSUM_SEED) + 16'(r.report_byte_4) + 16'(r.report_byte_5)
				+ 16'(r.report_byte_6) + 16'(r.report_byte_7) + 16'(r.report_byte_8);
			if (got != want) begin
				res.status = STATUS_CHECKSUM;
				return res;
			end
			res.touching = (r.report_byte_8[7:4] != 4'h0);
			rx = {r.report_byte_7[3:0], r.report_byte_4};
			ry = {r.report_byte_7[7:4], r.report_byte_5};
			// X is one-based in frame mode, but zero stays zero
			if (rx != '0)
				rx = rx - RAW_W'(1);
		end else begin
			ev = r.report_byte_3[7:6];
			if (ev == EV_ERROR) begin
				res.status = STATUS_BAD_EVENT;
				return res;
			end
			res.touching = (ev != EV_UP);
			rx = {r.report_byte_3[3:0], r.report_byte_4};
			ry = {r.report_byte_5[3:0], r.report_byte_6};
		end
		if (rx > RAW_W'(X_LIMIT))
			rx = RAW_W'(X_LIMIT);
		if (ry > RAW_W'(Y_LIMIT))
			ry = RAW_W'(Y_LIMIT);
		if (mode_q == MODE_FRAME)
			rx = RAW_W'(X_LIMIT) - rx;
		res.status   = STATUS_OK;
		res.screen_x = scale_axis(32'(rx), 32'(x_max_q), X_LIMIT);
		res.screen_y = scale_axis(32'(ry), 32'(y_max_q), Y_LIMIT);
		return res;
	endfunction

	// Fill in the checksum bytes of a frame-mode report
	function automatic report_t seal_frame(report_t r);
		logic [15:0] sum;
		sum = 16'(CHECKSUM_SEED) + 16'(r.report_byte_4) + 16'(r.report_byte_5)
			+ 16'(r.report_byte_6) + 16'(r.report_byte_7) + 16'(r.report_byte_8);
		r.report_byte_0 = sum[7:0];
		r.report_byte_1 = sum[15:8];
		return r;
	endfunction

	function automatic report_t frame_report(logic [7:0] b4, logic [7:0] b5, logic [7:0] b6,
			logic [7:0] b7, logic [7:0] b8);
		report_t r;
		r = '0;
		r.report_byte_4 = b4;
		r.report_byte_5 = b5;
		r.report_byte_6 = b6;
		r.report_byte_7 = b7;
		r.report_byte_8 = b8;
		return seal_frame(r);
	endfunction

	function automatic report_t reg_report(logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
			logic [7:0] b6);
		report_t r;
		r = '0;
		r.report_byte_3 = b3;
		r.report_byte_4 = b4;
		r.report_byte_5 = b5;
		r.report_byte_6 = b6;
		return r;
	endfunction

	// Random report: half keep raw values at most just past the clamp limits, most frames carry a good checksum
	function automatic report_t random_report(logic mode);
		report_t r;
		bit      y_high;
		r = {$urandom, $urandom};
		y_high = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1) == 0) begin
			if (mode == MODE_FRAME) begin
				r.report_byte_4 = 8'($urandom_range(0, 241));
				r.report_byte_7 = {3'b000, y_high, 4'h0};
				if (y_high)
					r.report_byte_5 = 8'($urandom_range(0, 65));
			end else begin
				r.report_byte_3[3:0] = 4'h0;
				r.report_byte_4      = 8'($urandom_range(0, 241));
				r.report_byte_5[3:0] = {3'b000, y_high};
				if (y_high)
					r.report_byte_6 = 8'($urandom_range(0, 65));
			end
		end
		if (mode == MODE_FRAME && $urandom_range(0, 7) != 0)
			r = seal_frame(r);
		return r;
	endfunction

	task automatic add_row(input logic mode, input report_t r, input bit fixed,
			input result_t want);
		directed_row_t row;
		row.mode  = mode;
		row.rpt   = r;
		row.fixed = fixed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("result %0d: %s got %0d expected %0d", checked_count, field, got, want);
		error_count++;
	endtask

	// Write one register; the local copy follows the same rules as the unit
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= data;
		@(posedge clk);
		case (idx)
			REG_PROTOCOL_MODE: mode_q = data[0];
			REG_SCREEN_X_MAX: x_max_q = data;
			REG_SCREEN_Y_MAX: y_max_q = data;
			default: ;
		endcase
	endtask

	// Offer one item, optionally after a gap; return at the edge that takes it
	task automatic send_report(input report_t r, input bit fixed, input result_t want,
			input bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			report_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		report_valid <= 1'b1;
		report       <= r;
		@(posedge clk);
		while (report_stall)
			@(posedge clk);
		pending_results.push_back(fixed ? want : decode_and_scale(r));
	endtask

	// Stop offering and wait until every result is back
	task automatic drain_results();
		report_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Count cycles and end a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[touch_frame_decode_scale_unit] ERROR");
			$finish;
		end
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			checked_count++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(result.status), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 32'(result.status), 32'(want.status));
				if (result.touching !== want.touching)
					report_mismatch("touching", 32'(result.touching), 32'(want.touching));
				if (result.screen_x !== want.screen_x)
					report_mismatch("screen_x", 32'(result.screen_x), 32'(want.screen_x));
				if (result.screen_y !== want.screen_y)
					report_mismatch("screen_y", 32'(result.screen_y), 32'(want.screen_y));
			end
		end
	end

	// Receiver pacing: random stall bursts, one long hold on request, none when quiet
	initial begin : result_pacing
		result_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (quiet) begin
				result_stall <= 1'b0;
				@(posedge clk);
			end else begin
				result_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		phase_t phases[NUM_PHASES];
		result_t no_result;
		no_result     = '0;
		error_count   = 0;
		checked_count = 0;
		cycle_count   = 0;
		hold_req      = 1'b0;
		quiet         = 1'b0;
		mode_q        = MODE_FRAME;
		x_max_q       = SCREEN_X_MAX_RESET;
		y_max_q       = SCREEN_Y_MAX_RESET;

		arst_n       <= 1'b0;
		report_valid <= 1'b0;
		report       <= '0;
		cfg_write_en <= 1'b0;
		cfg_index    <= REG_PROTOCOL_MODE;
		cfg_data     <= '0;

		// Frame mode under reset settings
		add_row(MODE_FRAME, frame_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
			'{STATUS_OK, 1'b0, 16'd239, 16'd0});
		add_row(MODE_FRAME, '0, 1'b1, '{STATUS_CHECKSUM, 1'b0, 16'd0, 16'd0});
		add_row(MODE_FRAME, frame_report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 1'b1,
			'{STATUS_OK, 1'b1, 16'd0, 16'd319});
		add_row(MODE_FRAME, frame_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, no_result);
		add_row(MODE_FRAME, frame_report(8'h02, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, no_result);
		add_row(MODE_FRAME, frame_report(8'hf0, 8'h10, 8'h00, 8'h00, 8'h00), 1'b0, no_result);
		add_row(MODE_FRAME, frame_report(8'hf1, 8'h20, 8'h00, 8'h00, 8'h20), 1'b0, no_result);
		add_row(MODE_FRAME, frame_report(8'h40, 8'h3f, 8'h00, 8'h10, 8'h30), 1'b0, no_result);
		add_row(MODE_FRAME, frame_report(8'h40, 8'h40, 8'h00, 8'h10, 8'h00), 1'b0, no_result);
		add_row(MODE_FRAME, frame_report(8'h80, 8'h80, 8'h00, 8'h00, 8'h10), 1'b0, no_result);
		add_row(MODE_FRAME, frame_report(8'h80, 8'h80, 8'h00, 8'h00, 8'h0f), 1'b0, no_result);
		add_row(MODE_FRAME, frame_report(8'hc0, 8'he0, 8'hff, 8'h01, 8'hf0), 1'b0, no_result);
		// Low byte right, high byte wrong
		add_row(MODE_FRAME, '{8'h35, 8'h02, 8'h00, 8'h10, 8'h20, 8'h30, 8'h00, 8'h80}, 1'b1,
			'{STATUS_CHECKSUM, 1'b0, 16'd0, 16'd0});
		// Register mode, every event code
		add_row(MODE_REGISTER, reg_report({EV_DOWN, 6'h00}, 8'h00, 8'h00, 8'h00), 1'b1,
			'{STATUS_OK, 1'b1, 16'd0, 16'd0});
		add_row(MODE_REGISTER, reg_report({EV_UP, 6'h00}, 8'h78, 8'h00, 8'ha0), 1'b0, no_result);
		add_row(MODE_REGISTER, reg_report({EV_CONTACT, 6'h00}, 8'hf0, 8'h01, 8'h3f), 1'b0,
			no_result);
		add_row(MODE_REGISTER, reg_report({EV_CONTACT, 6'h0f}, 8'hff, 8'h0f, 8'hff), 1'b1,
			'{STATUS_OK, 1'b1, 16'd239, 16'd319});
		add_row(MODE_REGISTER, '{8'hff, 8'hff, {EV_ERROR, 6'h3f}, 8'hff, 8'hff, 8'hff, 8'hff,
			8'hff}, 1'b1, '{STATUS_BAD_EVENT, 1'b0, 16'd0, 16'd0});
		add_row(MODE_REGISTER, reg_report({EV_ERROR, 6'h00}, 8'h00, 8'h00, 8'h00), 1'b1,
			'{STATUS_BAD_EVENT, 1'b0, 16'd0, 16'd0});
		// Upper nibbles and frame-only bytes are ignored here
		add_row(MODE_REGISTER, '{8'hff, 8'hff, {EV_DOWN, 6'h30}, 8'hef, 8'hf1, 8'h3f, 8'hff,
			8'hff}, 1'b0, no_result);
		add_row(MODE_REGISTER, reg_report({EV_UP, 6'h00}, 8'h01, 8'h01, 8'h40), 1'b0, no_result);

		// Settings per random phase, extremes included; the first one runs the long hold
		phases[0] = '{MODE_FRAME, 16'd239, 16'd319, 1'b0};
		phases[1] = '{MODE_REGISTER, 16'd0, 16'hffff, 1'b1};
		phases[2] = '{MODE_FRAME, 16'hffff, 16'd0, 1'b1};
		phases[3] = '{MODE_REGISTER, 16'd1, 16'd1, 1'b1};
		phases[4] = '{MODE_FRAME, 16'($urandom), 16'($urandom), 1'b1};
		phases[5] = '{MODE_REGISTER, 16'($urandom), 16'($urandom), 1'b1};
		phases[6] = '{MODE_FRAME, 16'hffff, 16'hffff, 1'b1};
		phases[7] = '{MODE_REGISTER, 16'd239, 16'd319, 1'b0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, switching mode only once the unit is empty
		foreach (directed_rows[i]) begin
			if (directed_rows[i].mode != mode_q) begin
				drain_results();
				write_reg(REG_PROTOCOL_MODE, CFG_DATA_W'(directed_rows[i].mode));
				cfg_write_en <= 1'b0;
			end
			send_report(directed_rows[i].rpt, directed_rows[i].fixed, directed_rows[i].want, 1'b1);
		end

		// Random phases, each under its own settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			if (p == 0)
				hold_req = 1'b1;
			if (p == NUM_PHASES - 1)
				quiet = 1'b1;
			write_reg(REG_PROTOCOL_MODE, CFG_DATA_W'(phases[p].mode));
			write_reg(REG_SCREEN_X_MAX, phases[p].x_max);
			write_reg(REG_SCREEN_Y_MAX, phases[p].y_max);
			write_reg(REG_UNMAPPED, 16'($urandom));
			cfg_write_en <= 1'b0;
			repeat (PHASE_ITEMS)
				send_report(random_report(mode_q), 1'b0, no_result, phases[p].gaps);
		end

		drain_results();
		if (error_count == 0)
			$display("[touch_frame_decode_scale_unit] OK");
		else
			$display("[touch_frame_decode_scale_unit] ERROR");
		$finish;
	end

endmodule
